FILE: rtl/core/tfr_pkg.sv
// Shared types, constants and helper functions of the telemetry frame receiver.
package tfr_pkg;

  localparam int unsigned PAYLOAD_LEN = 23;
  localparam int unsigned PAY_AW      = $clog2(PAYLOAD_LEN);
  localparam int unsigned NUM_CHAN    = 18;
  localparam int unsigned CHAN_W      = 5;
  localparam int unsigned VALUE_W     = 17;

  localparam logic [7:0]        TELEM_TYPE = 8'hFF;
  localparam logic [CHAN_W-1:0] LAST_CHAN  = CHAN_W'(NUM_CHAN - 1);

  // Result kinds
  typedef enum logic [1:0] {
    KIND_EVENT  = 2'd0,
    KIND_TELEM  = 2'd1,
    KIND_CRCERR = 2'd2
  } kind_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_START_BYTE = 2'd0,
    CFG_CRC_POLY   = 2'd1,
    CFG_CRC_INIT   = 2'd2
  } cfg_idx_t;

  // Receive / drain sequencer
  typedef enum logic [2:0] {
    ST_RX    = 3'b001,
    ST_FETCH = 3'b010,
    ST_USE   = 3'b100
  } state_t;

  // One byte through a non-reflected CRC-8
  function automatic logic [7:0] crc_feed(input logic [7:0] acc, input logic [7:0] b,
                                          input logic [7:0] poly);
    logic [7:0] c;
    c = acc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

  // Channels built from a little-endian byte pair
  function automatic logic chan_is_word(input logic [CHAN_W-1:0] ch);
    return (ch >= CHAN_W'(1)) && (ch <= CHAN_W'(5));
  endfunction

  // Amount subtracted from the raw field to give the channel's unit
  function automatic logic signed [VALUE_W-1:0] chan_offset(input logic [CHAN_W-1:0] ch);
    logic signed [VALUE_W-1:0] off;
    unique case (ch)
      CHAN_W'(0): off = -VALUE_W'(48);
      CHAN_W'(1): off = VALUE_W'(100);
      CHAN_W'(2): off = VALUE_W'(2880);
      CHAN_W'(3): off = VALUE_W'(2880);
      CHAN_W'(5): off = VALUE_W'(3000);
      default:    off = '0;
    endcase
    return off;
  endfunction

  // Event codes with a defined meaning
  function automatic logic code_known(input logic [7:0] c);
    return ((c >= 8'd2) && (c <= 8'd7)) || (c == 8'd16);
  endfunction

endpackage

FILE: rtl/core/telemetry_frame_receiver.sv
// Top level of the telemetry frame receiver: byte parser, CRC check and channel decode.
//
// Radio bytes enter one beat per cycle on the in_ channel while in_ready is high.
// While idle the block drops every byte until the start byte, then takes a type
// byte (type 0 is skipped and another awaited), 23 payload bytes when the type is
// 255, and a closing CRC-8 byte (non-reflected, no final xor, polynomial and initial
// value from cfg_). A good event frame gives one beat with its code and a known-code
// flag; a bad CRC gives one error beat; a good telemetry frame gives 18 channel beats,
// temperature first, the last one flagged. The payload sits in a 23-entry RAM with one
// read port and registered read data, and the channel burst reads it one byte at a
// time, each byte through the FETCH and then the USE state, while in_ready is low.
// The payload RAM is never cleared; each burst reads only bytes of its own frame.
module telemetry_frame_receiver (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  // received bytes
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  // results
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_code,
  output logic              out_known,
  output logic [4:0]        out_channel,
  output logic signed [16:0] out_value,
  output logic              out_last
);

  // configuration registers
  logic [7:0] start_byte_r, start_byte_nxt;
  logic [7:0] crc_poly_r,   crc_poly_nxt;
  logic [7:0] crc_init_r,   crc_init_nxt;

  // frame parser state
  tfr_pkg::state_t state_r, state_nxt;
  logic       in_frame_r,   in_frame_nxt;
  logic       have_type_r,  have_type_nxt;
  logic [7:0] frame_type_r, frame_type_nxt;
  logic [4:0] bytes_left_r, bytes_left_nxt;
  logic [7:0] crc_acc_r,    crc_acc_nxt;

  // channel drain sequencer
  logic [tfr_pkg::PAY_AW-1:0] rd_addr_r, rd_addr_nxt;
  logic [tfr_pkg::CHAN_W-1:0] ch_r,      ch_nxt;
  logic                       lo_have_r, lo_have_nxt;
  logic [7:0]                 lo_r,      lo_nxt;

  // output register
  logic                                out_valid_r,   out_valid_nxt;
  logic [1:0]                          out_kind_r,    out_kind_nxt;
  logic [7:0]                          out_code_r,    out_code_nxt;
  logic                                out_known_r,   out_known_nxt;
  logic [tfr_pkg::CHAN_W-1:0]          out_channel_r, out_channel_nxt;
  logic signed [tfr_pkg::VALUE_W-1:0]  out_value_r,   out_value_nxt;
  logic                                out_last_r,    out_last_nxt;

  // payload RAM
  logic                       ram_we, ram_re;
  logic [tfr_pkg::PAY_AW-1:0] ram_waddr;
  logic [7:0]                 ram_rdata;

  logic                               slot_free;
  logic                               in_acc;
  logic [7:0]                         crc_next_byte;
  logic                               is_word;
  logic [tfr_pkg::VALUE_W-1:0]        raw_field;
  logic signed [tfr_pkg::VALUE_W-1:0] chan_value;

  // the output register is free, or frees at this edge
  assign slot_free = !out_valid_r || out_ready;
  // take bytes only while parsing and with room for a possible result
  assign in_ready  = (state_r == tfr_pkg::ST_RX) && slot_free;
  assign in_acc    = in_valid && in_ready;

  assign crc_next_byte = tfr_pkg::crc_feed(crc_acc_r, in_rx_byte, crc_poly_r);

  // payload index of the byte in flight: 23 minus bytes still to come
  assign ram_waddr = tfr_pkg::PAY_AW'(5'(tfr_pkg::PAYLOAD_LEN) - bytes_left_r);

  // word channels pair the held low byte with the byte just read
  assign is_word    = tfr_pkg::chan_is_word(ch_r);
  assign raw_field  = is_word ? {1'b0, ram_rdata, lo_r} : {9'b0, ram_rdata};
  assign chan_value = $signed(raw_field) - tfr_pkg::chan_offset(ch_r);

  tfr_ram #(
    .Width (8),
    .Depth (tfr_pkg::PAYLOAD_LEN)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_rx_byte),
    .re    (ram_re),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    start_byte_nxt  = start_byte_r;
    crc_poly_nxt    = crc_poly_r;
    crc_init_nxt    = crc_init_r;
    state_nxt       = state_r;
    in_frame_nxt    = in_frame_r;
    have_type_nxt   = have_type_r;
    frame_type_nxt  = frame_type_r;
    bytes_left_nxt  = bytes_left_r;
    crc_acc_nxt     = crc_acc_r;
    rd_addr_nxt     = rd_addr_r;
    ch_nxt          = ch_r;
    lo_have_nxt     = lo_have_r;
    lo_nxt          = lo_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_kind_nxt    = out_kind_r;
    out_code_nxt    = out_code_r;
    out_known_nxt   = out_known_r;
    out_channel_nxt = out_channel_r;
    out_value_nxt   = out_value_r;
    out_last_nxt    = out_last_r;
    ram_we          = 1'b0;
    ram_re          = 1'b0;

    // register writes; indexes beyond the list are dropped
    if (cfg_we) begin
      unique case (cfg_index)
        tfr_pkg::CFG_START_BYTE: start_byte_nxt = cfg_data;
        tfr_pkg::CFG_CRC_POLY:   crc_poly_nxt   = cfg_data;
        tfr_pkg::CFG_CRC_INIT:   crc_init_nxt   = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      tfr_pkg::ST_RX: begin
        if (in_acc) begin
          priority if (!in_frame_r) begin
            // hunt for the start byte, drop the rest
            if (in_rx_byte == start_byte_r) begin
              in_frame_nxt   = 1'b1;
              have_type_nxt  = 1'b0;
              frame_type_nxt = '0;
              bytes_left_nxt = '0;
              crc_acc_nxt    = crc_init_r;
            end
          end else if (!have_type_r) begin
            // type byte; a zero type is checksummed and skipped
            crc_acc_nxt = crc_next_byte;
            if (in_rx_byte != 8'd0) begin
              have_type_nxt  = 1'b1;
              frame_type_nxt = in_rx_byte;
              bytes_left_nxt = (in_rx_byte == tfr_pkg::TELEM_TYPE) ?
                               5'(tfr_pkg::PAYLOAD_LEN) : 5'd0;
            end
          end else if (bytes_left_r != 5'd0) begin
            // payload byte: store and checksum
            ram_we         = 1'b1;
            crc_acc_nxt    = crc_next_byte;
            bytes_left_nxt = bytes_left_r - 5'd1;
          end else begin
            // closing CRC byte
            in_frame_nxt  = 1'b0;
            have_type_nxt = 1'b0;
            priority if (in_rx_byte != crc_acc_r) begin
              out_valid_nxt   = 1'b1;
              out_kind_nxt    = tfr_pkg::KIND_CRCERR;
              out_code_nxt    = '0;
              out_known_nxt   = 1'b0;
              out_channel_nxt = '0;
              out_value_nxt   = '0;
              out_last_nxt    = 1'b1;
            end else if (frame_type_r != tfr_pkg::TELEM_TYPE) begin
              out_valid_nxt   = 1'b1;
              out_kind_nxt    = tfr_pkg::KIND_EVENT;
              out_code_nxt    = frame_type_r;
              out_known_nxt   = tfr_pkg::code_known(frame_type_r);
              out_channel_nxt = '0;
              out_value_nxt   = '0;
              out_last_nxt    = 1'b1;
            end else begin
              // good telemetry frame: drain the channels from the payload RAM
              state_nxt   = tfr_pkg::ST_FETCH;
              rd_addr_nxt = '0;
              ch_nxt      = '0;
              lo_have_nxt = 1'b0;
            end
          end
        end
      end

      tfr_pkg::ST_FETCH: begin
        ram_re    = 1'b1;
        state_nxt = tfr_pkg::ST_USE;
      end

      tfr_pkg::ST_USE: begin
        priority if (is_word && !lo_have_r) begin
          // hold the low byte, fetch the high one
          lo_nxt      = ram_rdata;
          lo_have_nxt = 1'b1;
          rd_addr_nxt = rd_addr_r + tfr_pkg::PAY_AW'(1);
          state_nxt   = tfr_pkg::ST_FETCH;
        end else if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = tfr_pkg::KIND_TELEM;
          out_code_nxt    = '0;
          out_known_nxt   = 1'b0;
          out_channel_nxt = ch_r;
          out_value_nxt   = chan_value;
          out_last_nxt    = (ch_r == tfr_pkg::LAST_CHAN);
          rd_addr_nxt     = rd_addr_r + tfr_pkg::PAY_AW'(1);
          ch_nxt          = ch_r + tfr_pkg::CHAN_W'(1);
          lo_have_nxt     = 1'b0;
          state_nxt       = (ch_r == tfr_pkg::LAST_CHAN) ? tfr_pkg::ST_RX : tfr_pkg::ST_FETCH;
        end else begin
          // output stalled: hold, read data stays put
        end
      end

      default: state_nxt = tfr_pkg::ST_RX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= 8'd1;
      crc_poly_r   <= 8'd7;
      crc_init_r   <= 8'd0;
      state_r      <= tfr_pkg::ST_RX;
      in_frame_r   <= 1'b0;
      have_type_r  <= 1'b0;
      frame_type_r <= '0;
      bytes_left_r <= '0;
      crc_acc_r    <= 8'd0;
      rd_addr_r    <= '0;
      ch_r         <= '0;
      lo_have_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      start_byte_r <= start_byte_nxt;
      crc_poly_r   <= crc_poly_nxt;
      crc_init_r   <= crc_init_nxt;
      state_r      <= state_nxt;
      in_frame_r   <= in_frame_nxt;
      have_type_r  <= have_type_nxt;
      frame_type_r <= frame_type_nxt;
      bytes_left_r <= bytes_left_nxt;
      crc_acc_r    <= crc_acc_nxt;
      rd_addr_r    <= rd_addr_nxt;
      ch_r         <= ch_nxt;
      lo_have_r    <= lo_have_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload of the output beat and the held low byte
  always_ff @(posedge clk) begin
    lo_r          <= lo_nxt;
    out_kind_r    <= out_kind_nxt;
    out_code_r    <= out_code_nxt;
    out_known_r   <= out_known_nxt;
    out_channel_r <= out_channel_nxt;
    out_value_r   <= out_value_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_code    = out_code_r;
  assign out_known   = out_known_r;
  assign out_channel = out_channel_r;
  assign out_value   = out_value_r;
  assign out_last    = out_last_r;

endmodule

FILE: rtl/core/tfr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/tfr_checker.sv
// Port-level assertions on the result channel of the telemetry frame receiver.
module tfr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        out_kind,
  input logic [7:0]        out_code,
  input logic              out_known,
  input logic [4:0]        out_channel,
  input logic signed [16:0] out_value,
  input logic              out_last
);

  // a stalled beat holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_channel)
      && $stable(out_value) && $stable(out_last))
    else $error("result beat changed while stalled");

  // event and error beats are single-beat runs with no channel data
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == tfr_pkg::KIND_EVENT || out_kind == tfr_pkg::KIND_CRCERR)
      |-> out_last && out_channel == 5'd0 && out_value == 17'sd0)
    else $error("event or error beat malformed");

  // error beats carry no code
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == tfr_pkg::KIND_CRCERR |-> out_code == 8'd0 && !out_known)
    else $error("error beat carries a code");

  // telemetry beats: last exactly on the final channel, channel in range
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == tfr_pkg::KIND_TELEM
      |-> out_channel <= tfr_pkg::LAST_CHAN && (out_last == (out_channel == tfr_pkg::LAST_CHAN)))
    else $error("telemetry beat channel or last flag wrong");

  // channels of a burst advance one at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind == tfr_pkg::KIND_TELEM && !out_last
      ##1 out_valid && out_kind == tfr_pkg::KIND_TELEM
      |-> out_channel == $past(out_channel) + 5'd1 || $past(out_valid, 1) == 1'b0)
    else $error("telemetry channel skipped");

endmodule

bind telemetry_frame_receiver tfr_checker u_tfr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_kind    (out_kind),
  .out_code    (out_code),
  .out_known   (out_known),
  .out_channel (out_channel),
  .out_value   (out_value),
  .out_last    (out_last)
);

FILE: tb/tfr_frame_check.sv
// Predicts telemetry frame receiver result beats from accepted bytes and compares them.
module tfr_frame_check
  import tfr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [7:0]                cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [7:0]                in_rx_byte,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [1:0]                out_kind,
  input  logic [7:0]                out_code,
  input  logic                      out_known,
  input  logic [CHAN_W-1:0]         out_channel,
  input  logic signed [VALUE_W-1:0] out_value,
  input  logic                      out_last,
  output int                        fail_count,
  output int                        results_due
);

  typedef struct packed {
    kind_t                      kind;
    logic [7:0]                 code;
    logic                       known;
    logic [CHAN_W-1:0]          channel;
    logic signed [VALUE_W-1:0]  value;
    logic                       last;
  } frame_result_t;

  frame_result_t frame_results_due[$];

  // shadow registers and parser state
  logic [7:0] start_sel, poly_sel, init_sel;
  logic       in_frame, have_type;
  logic [7:0] frame_type, crc_acc;
  logic [4:0] bytes_left;
  logic [7:0] payload_mem [PAYLOAD_LEN];
  int         beat_no;

  initial begin
    fail_count  = 0;
    results_due = 0;
    beat_no     = 0;
  end

  task automatic report(input string msg);
    $display("%0t tfr_frame_check: beat %0d: %s", $time, beat_no, msg);
    fail_count++;
  endtask

  function automatic logic [7:0] crc_after(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    repeat (8) c = c[7] ? ({c[6:0], 1'b0} ^ poly_sel) : {c[6:0], 1'b0};
    return c;
  endfunction

  // Decoded value of one telemetry channel in its fixed unit
  function automatic logic signed [VALUE_W-1:0] channel_value(input int ch);
    int v;
    case (ch)
      0:       v = int'(payload_mem[0]) + 48;
      1:       v = int'({payload_mem[2], payload_mem[1]}) - 100;
      2:       v = int'({payload_mem[4], payload_mem[3]}) - 2880;
      3:       v = int'({payload_mem[6], payload_mem[5]}) - 2880;
      4:       v = int'({payload_mem[8], payload_mem[7]});
      5:       v = int'({payload_mem[10], payload_mem[9]}) - 3000;
      default: v = int'(payload_mem[ch + 5]);
    endcase
    return VALUE_W'(v);
  endfunction

  task automatic parse_rx_byte(input logic [7:0] b);
    frame_result_t r;
    if (!in_frame) begin
      if (b == start_sel) begin
        in_frame   = 1'b1;
        have_type  = 1'b0;
        frame_type = 8'h00;
        bytes_left = '0;
        crc_acc    = init_sel;
      end
    end else if (!have_type) begin
      crc_acc = crc_after(crc_acc, b);
      if (b != 8'h00) begin
        have_type  = 1'b1;
        frame_type = b;
        bytes_left = (b == TELEM_TYPE) ? 5'(PAYLOAD_LEN) : 5'd0;
      end
    end else if (bytes_left != 0) begin
      payload_mem[PAYLOAD_LEN - int'(bytes_left)] = b;
      crc_acc    = crc_after(crc_acc, b);
      bytes_left = bytes_left - 5'd1;
    end else begin
      in_frame  = 1'b0;
      have_type = 1'b0;
      r = '0;
      r.last = 1'b1;
      if (b != crc_acc) begin
        r.kind = KIND_CRCERR;
        frame_results_due.push_back(r);
      end else if (frame_type != TELEM_TYPE) begin
        r.kind  = KIND_EVENT;
        r.code  = frame_type;
        r.known = ((frame_type >= 8'd2) && (frame_type <= 8'd7)) || (frame_type == 8'd16);
        frame_results_due.push_back(r);
      end else begin
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
          r.kind    = KIND_TELEM;
          r.channel = CHAN_W'(ch);
          r.value   = channel_value(ch);
          r.last    = (ch == NUM_CHAN - 1);
          frame_results_due.push_back(r);
        end
      end
    end
  endtask

  task automatic check_result_beat();
    frame_result_t want;
    if (frame_results_due.size() == 0) begin
      report($sformatf("result beat kind %0d with nothing due", out_kind));
    end else begin
      want = frame_results_due.pop_front();
      if (out_kind !== want.kind)
        report($sformatf("kind %0d, want %0d", out_kind, want.kind));
      if (out_code !== want.code)
        report($sformatf("code %0d, want %0d", out_code, want.code));
      if (out_known !== want.known)
        report($sformatf("known %0b, want %0b", out_known, want.known));
      if (out_channel !== want.channel)
        report($sformatf("channel %0d, want %0d", out_channel, want.channel));
      if (out_value !== want.value)
        report($sformatf("value %0d, want %0d", out_value, want.value));
      if (out_last !== want.last)
        report($sformatf("last %0b, want %0b", out_last, want.last));
    end
    beat_no++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start_sel  = 8'h01;
      poly_sel   = 8'h07;
      init_sel   = 8'h00;
      in_frame   = 1'b0;
      have_type  = 1'b0;
      frame_type = 8'h00;
      bytes_left = '0;
      crc_acc    = 8'h00;
      frame_results_due.delete();
    end else begin
      if (out_valid && out_ready) check_result_beat();
      if (in_valid && in_ready) parse_rx_byte(in_rx_byte);
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_BYTE: start_sel = cfg_data;
          CFG_CRC_POLY:   poly_sel  = cfg_data;
          CFG_CRC_INIT:   init_sel  = cfg_data;
          default:        ;
        endcase
      end
    end
    results_due = frame_results_due.size();
  end

endmodule

FILE: tb/telemetry_frame_receiver_test.sv
// Stimulus and verdict for the telemetry frame receiver, checked by tfr_frame_check.
module telemetry_frame_receiver_test;
  import tfr_pkg::*;

  // Longest run of cycles without any accepted beat or register write before giving up
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles to let pass once every result has come: covers a whole channel burst
  localparam int DRAIN_CYCLES   = 64;
  // Register index the block must ignore
  localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

  typedef enum int {FILL_ZERO, FILL_ONES, FILL_RANDOM, FILL_MIXED} fill_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [1:0]                cfg_index = CFG_START_BYTE;
  logic [7:0]                cfg_data = 8'h00;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [7:0]                in_rx_byte = 8'h00;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [1:0]                out_kind;
  logic [7:0]                out_code;
  logic                      out_known;
  logic [CHAN_W-1:0]         out_channel;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_last;

  int fail_count;
  int results_due;

  // Idling control: percentage of cycles each side holds off, and calm stretches
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int send_calm    = 0;
  int recv_calm    = 0;

  // Configuration as last written, used to build well-formed frames
  logic [7:0] cur_start = 8'h01;
  logic [7:0] cur_poly  = 8'h07;
  logic [7:0] cur_init  = 8'h00;

  int beats_sent  = 0;
  int tele_frames = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  telemetry_frame_receiver u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_rx_byte  (in_rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_code    (out_code),
    .out_known   (out_known),
    .out_channel (out_channel),
    .out_value   (out_value),
    .out_last    (out_last)
  );

  tfr_frame_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_rx_byte  (in_rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_code    (out_code),
    .out_known   (out_known),
    .out_channel (out_channel),
    .out_value   (out_value),
    .out_last    (out_last),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  // Result side: stall at random, with the odd calm stretch where ready stays high
  always @(negedge clk) begin
    if (recv_calm != 0) begin
      out_ready <= 1'b1;
      recv_calm <= recv_calm - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
      if ($urandom_range(0, 63) == 0) recv_calm <= $urandom_range(10, 60);
    end
  end

  // Watchdog: restart on any accepted beat or register write, give up after a long silence
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("[telemetry_frame_receiver] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    repeat (8) c = c[7] ? ({c[6:0], 1'b0} ^ cur_poly) : {c[6:0], 1'b0};
    return c;
  endfunction

  function automatic logic [7:0] fill_byte(input fill_t fill);
    case (fill)
      FILL_ZERO:   return 8'h00;
      FILL_ONES:   return 8'hFF;
      FILL_RANDOM: return 8'($urandom_range(0, 255));
      default: begin
        case ($urandom_range(0, 2))
          0:       return 8'h00;
          1:       return 8'hFF;
          default: return 8'($urandom_range(0, 255));
        endcase
      end
    endcase
  endfunction

  // Offer one byte beat, idling first if the sender is due a gap, and hold it until taken.
  // Called at a falling edge; returns at the falling edge after acceptance with valid still
  // high, so the caller must drive valid again in that same step.
  task automatic send_beat(input logic [7:0] b);
    while (send_calm == 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    if (send_calm != 0) send_calm--;
    else if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(8, 40);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid, wait for every due result, then let the block fall quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write all three registers plus the unused index, one per cycle; call only when settled
  task automatic load_config(input logic [7:0] sb, input logic [7:0] poly,
                             input logic [7:0] init);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_BYTE;
    cfg_data  <= sb;
    @(negedge clk);
    cfg_index <= CFG_CRC_POLY;
    cfg_data  <= poly;
    @(negedge clk);
    cfg_index <= CFG_CRC_INIT;
    cfg_data  <= init;
    @(negedge clk);
    cfg_index <= CFG_UNUSED_IDX;
    cfg_data  <= 8'($urandom_range(0, 255));
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_start = sb;
    cur_poly  = poly;
    cur_init  = init;
  endtask

  // Event frame: start, optional zero type bytes, code, closing CRC (corrupted on request)
  task automatic send_event(input logic [7:0] code, input int zero_types, input bit corrupt);
    logic [7:0] crc;
    crc = cur_init;
    send_beat(cur_start);
    repeat (zero_types) begin
      crc = crc_step(crc, 8'h00);
      send_beat(8'h00);
    end
    crc = crc_step(crc, code);
    send_beat(code);
    if (corrupt) crc ^= 8'($urandom_range(1, 255));
    send_beat(crc);
    beats_sent += zero_types + 3;
  endtask

  // Telemetry frame; keep below the payload length cuts it short with no CRC byte
  task automatic send_telemetry(input fill_t fill, input bit corrupt, input int keep);
    logic [7:0] crc;
    logic [7:0] b;
    crc = cur_init;
    send_beat(cur_start);
    crc = crc_step(crc, TELEM_TYPE);
    send_beat(TELEM_TYPE);
    for (int i = 0; i < keep; i++) begin
      b   = fill_byte(fill);
      crc = crc_step(crc, b);
      send_beat(b);
    end
    if (keep == PAYLOAD_LEN) begin
      if (corrupt) crc ^= 8'($urandom_range(1, 255));
      send_beat(crc);
      beats_sent++;
    end
    beats_sent += keep + 2;
  endtask

  function automatic fill_t next_fill();
    tele_frames++;
    // open with the all-zero and all-ones payloads: the extremes of every channel
    if (tele_frames == 1) return FILL_ZERO;
    if (tele_frames == 2) return FILL_ONES;
    case ($urandom_range(0, 9))
      0:       return FILL_ZERO;
      1:       return FILL_ONES;
      2, 3:    return FILL_MIXED;
      default: return FILL_RANDOM;
    endcase
  endfunction

  function automatic logic [7:0] pick_event_code();
    logic [7:0] known_codes [7] = '{8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd16};
    if ($urandom_range(0, 9) < 4) return known_codes[$urandom_range(0, 6)];
    return 8'($urandom_range(1, 254));
  endfunction

  // Mostly well-formed frames with random content; the rest is idle noise and broken frames
  task automatic run_random_phase(input int beats_wanted);
    int goal;
    int pick;
    logic [7:0] noise;
    goal = beats_sent + beats_wanted;
    while (beats_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send_telemetry(next_fill(), $urandom_range(0, 6) == 0, PAYLOAD_LEN);
      end else if (pick < 80) begin
        send_event(pick_event_code(),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0,
                   $urandom_range(0, 5) == 0);
      end else if (pick < 90) begin
        // idle noise: keep it off the start byte so it stays ignored
        repeat ($urandom_range(1, 3)) begin
          noise = 8'($urandom_range(0, 255));
          if (noise == cur_start) noise = ~noise;
          send_beat(noise);
          beats_sent++;
        end
      end else begin
        // broken frame: the next frame's bytes land in its payload
        send_telemetry(FILL_RANDOM, 1'b0, $urandom_range(0, PAYLOAD_LEN - 1));
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // sender idles a little, receiver a lot
    send_gap_pct = 27;
    recv_gap_pct = 58;
    load_config(8'h01, 8'h07, 8'h00);

    // directed: idle bytes, event codes at the edges of the known set, a skipped zero type,
    // the start byte used as a type, and a bad checksum
    send_beat(8'h5A);
    send_beat(8'h00);
    send_event(8'd2, 0, 1'b0);
    send_event(8'd16, 1, 1'b0);
    send_event(cur_start, 0, 1'b0);
    send_event(8'd7, 0, 1'b0);
    send_event(8'd8, 0, 1'b0);
    send_event(8'h80, 0, 1'b1);
    send_event(8'hFE, 0, 1'b0);
    settle();

    load_config(8'hA5, 8'h07, 8'h00);
    run_random_phase(62);
    settle();
    load_config(8'h00, 8'hFF, 8'hFF);
    run_random_phase(62);
    settle();

    // swap the idling: sender busy with gaps, receiver mostly ready
    send_gap_pct = 58;
    recv_gap_pct = 27;
    load_config(8'hFF, 8'h00, 8'h5C);
    run_random_phase(62);
    settle();
    load_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
    run_random_phase(62);
    settle();

    // no idling on either side
    send_gap_pct = 0;
    recv_gap_pct = 0;
    load_config(8'h01, 8'h31, 8'h00);
    run_random_phase(62);
    settle();
    load_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
    run_random_phase(62);
    settle();

    if (fail_count == 0 && results_due == 0) begin
      $display("[telemetry_frame_receiver] OK");
    end else begin
      $display("[telemetry_frame_receiver] ERROR");
    end
    $finish;
  end

endmodule
